>>> src/cici_pkg.sv
// Shared types, constants and helpers of the complex CIC interpolator.
// No dependencies; every other source file imports this package.
package cici_pkg;

  localparam int SMP_W     = 16;
  localparam int ACC_W     = 58;
  localparam int GAIN_W    = 33;
  localparam int CFG_W     = 33;
  localparam int IDX_W     = 3;
  localparam int MAX_ORDER = 6;
  localparam int MAX_RATIO = 64;
  localparam int MAX_DDLY  = 2;
  localparam int ORD_W     = 3;
  localparam int RAT_W     = 7;
  localparam int DD_W      = 2;
  localparam int PH_W      = 6;
  localparam int STG_W     = $clog2(MAX_ORDER);
  localparam int MUL_W     = 32;
  localparam int MAG_HI_W  = ACC_W - MUL_W;
  localparam int PROD_W    = ACC_W + GAIN_W;
  localparam int QUO_W     = PROD_W - MUL_W;

  // Register reset values
  localparam logic [ORD_W-1:0]  ORDER_RST = ORD_W'(5);
  localparam logic [RAT_W-1:0]  RATIO_RST = RAT_W'(2);
  localparam logic [DD_W-1:0]   DDLY_RST  = DD_W'(1);
  localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(268435456);

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    smp_t in_i;
    smp_t in_q;
  } in_t;

  typedef struct packed {
    smp_t out_i;
    smp_t out_q;
    logic last;
  } out_t;

  typedef struct packed {
    acc_t i;
    acc_t q;
  } cplx_t;

  // Effective configuration, already clamped to legal ranges
  typedef struct packed {
    logic [ORD_W-1:0]  ord;
    logic [RAT_W-1:0]  rat;
    logic              dd2;
    logic [PH_W-1:0]   phase;
    smp_t              fill_i;
    smp_t              fill_q;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // Comb result handed from front to queue
  typedef struct packed {
    logic  vld;
    cplx_t data;
  } push_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ORDER  = 3'd0,
    REG_RATIO  = 3'd1,
    REG_DDLY   = 3'd2,
    REG_PHASE  = 3'd3,
    REG_FILL_I = 3'd4,
    REG_FILL_Q = 3'd5,
    REG_GAIN   = 3'd6
  } cfg_reg_e;

  function automatic acc_t smp_to_acc(smp_t v);
    return {{(ACC_W-SMP_W){v[SMP_W-1]}}, v};
  endfunction

endpackage

>>> src/cici_comb.sv
// Front part: accepts an input item and runs it through the comb stages,
// one stage per cycle, then hands the result to the queue. Uses cici_pkg.
module cici_comb import cici_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  clr_i,
  input  logic  in_valid_i,
  input  in_t   in_data_i,
  output logic  in_ready_o,
  output push_t push_o,
  input  logic  push_ready_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_PUSH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [STG_W-1:0] stg_q;
  cplx_t            c_q;
  acc_t             dly_i_q [MAX_ORDER][MAX_DDLY];
  acc_t             dly_q_q [MAX_ORDER][MAX_DDLY];
  logic             pos_q   [MAX_ORDER];

  logic             idx;
  logic             last_stg;
  acc_t             diff_i, diff_q;

  // Pick the delay slot of the current stage and form the difference
  always_comb begin
    idx      = cfg_i.dd2 ? pos_q[stg_q] : 1'b0;
    diff_i   = c_q.i - dly_i_q[stg_q][idx];
    diff_q   = c_q.q - dly_q_q[stg_q][idx];
    last_stg = (ORD_W'(stg_q) == cfg_i.ord - ORD_W'(1));
  end

  // Sequence: idle, one comb stage per cycle, hand-off
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_RUN;
      ST_RUN:  if (last_stg) state_d = ST_PUSH;
      ST_PUSH: if (push_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Advance state and update the stage delay lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stg_q   <= '0;
      for (int s = 0; s < MAX_ORDER; s++) begin
        pos_q[s] <= 1'b0;
        for (int j = 0; j < MAX_DDLY; j++) begin
          dly_i_q[s][j] <= '0;
          dly_q_q[s][j] <= '0;
        end
      end
    end else if (clr_i) begin
      state_q <= ST_IDLE;
      stg_q   <= '0;
      for (int s = 0; s < MAX_ORDER; s++) begin
        pos_q[s] <= 1'b0;
        for (int j = 0; j < MAX_DDLY; j++) begin
          dly_i_q[s][j] <= '0;
          dly_q_q[s][j] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        stg_q <= '0;
      end else if (state_q == ST_RUN) begin
        dly_i_q[stg_q][idx] <= c_q.i;
        dly_q_q[stg_q][idx] <= c_q.q;
        pos_q[stg_q]        <= cfg_i.dd2 ? ~idx : 1'b0;
        stg_q               <= stg_q + STG_W'(1);
      end
    end
  end

  // Load the sample, then replace it by each stage's difference
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      c_q.i <= smp_to_acc(in_data_i.in_i);
      c_q.q <= smp_to_acc(in_data_i.in_q);
    end else if (state_q == ST_RUN) begin
      c_q.i <= diff_i;
      c_q.q <= diff_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign push_o.vld  = (state_q == ST_PUSH);
  assign push_o.data = c_q;

endmodule

>>> src/cici_queue.sv
// Two-entry queue of comb results between the front and the back part.
// Uses cici_pkg.
module cici_queue import cici_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  push_ready_o,
  input  logic  pop_i,
  output logic  head_vld_o,
  output cplx_t head_o
);

  cplx_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push;

  assign push_ready_o = (cnt_q != 2'd2);
  assign do_push      = push_i.vld && push_ready_o;
  assign head_vld_o   = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (do_push && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!do_push && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.data;
  end

endmodule

>>> src/cici_scale.sv
// Gain stage: floor(x * gain / 2^32) saturated to the sample width,
// four pipeline stages under a common enable. Uses cici_pkg.
module cici_scale import cici_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  acc_t              x_i,
  input  logic [GAIN_W-1:0] gain_i,
  output smp_t              y_o
);

  localparam logic [QUO_W-1:0]  POS_LIM = QUO_W'(2 ** (SMP_W - 1) - 1);
  localparam logic [QUO_W:0]    NEG_LIM = (QUO_W + 1)'(2 ** (SMP_W - 1));

  logic                neg1_q, neg2_q, neg3_q;
  logic [ACC_W-1:0]    mag1_q, hi2_q;
  logic [2*MUL_W-1:0]  p00_q;
  logic [ACC_W-1:0]    p10_q;
  logic [PROD_W-1:0]   prod_q;
  smp_t                y_q;

  logic [ACC_W-1:0]    mag;
  logic [QUO_W-1:0]    quo;
  logic [QUO_W:0]      quo_up;
  logic                frac;
  smp_t                y_d;

  // Magnitude of the accumulator
  assign mag = x_i[ACC_W-1] ? (~x_i + ACC_W'(1)) : x_i;

  // Round toward minus infinity and saturate
  always_comb begin
    quo    = prod_q[PROD_W-1:MUL_W];
    frac   = |prod_q[MUL_W-1:0];
    quo_up = {1'b0, quo} + (QUO_W + 1)'(frac);
    if (!neg3_q) begin
      y_d = (quo > POS_LIM) ? smp_t'(POS_LIM[SMP_W-1:0]) : smp_t'(quo[SMP_W-1:0]);
    end else begin
      y_d = (quo_up > NEG_LIM) ? smp_t'(NEG_LIM[SMP_W-1:0])
                               : smp_t'(~quo_up[SMP_W-1:0] + SMP_W'(1));
    end
  end

  // Magnitude, partial products, product sum, result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= x_i[ACC_W-1];
      mag1_q <= mag;
      neg2_q <= neg1_q;
      p00_q  <= mag1_q[MUL_W-1:0] * gain_i[MUL_W-1:0];
      p10_q  <= mag1_q[ACC_W-1:MUL_W] * gain_i[MUL_W-1:0];
      hi2_q  <= gain_i[GAIN_W-1] ? mag1_q : '0;
      neg3_q <= neg2_q;
      prod_q <= {{(PROD_W-2*MUL_W){1'b0}}, p00_q}
              + {{(PROD_W-ACC_W-MUL_W){1'b0}}, p10_q, {MUL_W{1'b0}}}
              + {{(PROD_W-ACC_W-MUL_W){1'b0}}, hi2_q, {MUL_W{1'b0}}};
      y_q    <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

>>> src/cici_integ.sv
// Back part: builds the high-rate slots, runs the pipelined integrator
// cascade and the gain stages, and drives the output register.
// Uses cici_pkg and cici_scale.
module cici_integ import cici_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  clr_i,
  input  logic  head_vld_i,
  input  cplx_t head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  localparam int SC_STG = 4;

  logic [PH_W-1:0] r_q;
  logic            slot_vld_q, slot_last_q;
  cplx_t           slot_v_q;
  logic            vld_q  [MAX_ORDER];
  logic            last_q [MAX_ORDER];
  cplx_t           v_q    [MAX_ORDER];
  cplx_t           acc_q  [MAX_ORDER];
  logic            sc_vld_q  [SC_STG];
  logic            sc_last_q [SC_STG];

  logic            en, issue, slot_last, hit;
  logic            in_vld  [MAX_ORDER];
  logic            in_last [MAX_ORDER];
  cplx_t           in_v    [MAX_ORDER];
  cplx_t           sum     [MAX_ORDER];
  smp_t            y_i, y_q;

  // Whole pipeline moves unless the output item is stalled
  assign en          = !sc_vld_q[SC_STG-1] || out_ready_i;
  assign issue       = en && head_vld_i;
  assign slot_last   = ({1'b0, r_q} == cfg_i.rat - RAT_W'(1));
  assign hit         = (r_q == cfg_i.phase);
  assign pop_o       = issue && slot_last;

  // Stage inputs and running sums
  always_comb begin
    for (int s = 0; s < MAX_ORDER; s++) begin
      if (s == 0) begin
        in_vld[s]  = slot_vld_q;
        in_last[s] = slot_last_q;
        in_v[s]    = slot_v_q;
      end else begin
        in_vld[s]  = vld_q[s-1];
        in_last[s] = last_q[s-1];
        in_v[s]    = v_q[s-1];
      end
      sum[s].i = acc_q[s].i + in_v[s].i;
      sum[s].q = acc_q[s].q + in_v[s].q;
    end
  end

  // Control: slot counter, valid flags, integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q        <= '0;
      slot_vld_q <= 1'b0;
      for (int s = 0; s < MAX_ORDER; s++) begin
        vld_q[s] <= 1'b0;
        acc_q[s] <= '0;
      end
      for (int k = 0; k < SC_STG; k++) sc_vld_q[k] <= 1'b0;
    end else if (clr_i) begin
      r_q        <= '0;
      slot_vld_q <= 1'b0;
      for (int s = 0; s < MAX_ORDER; s++) begin
        vld_q[s] <= 1'b0;
        acc_q[s] <= '0;
      end
      for (int k = 0; k < SC_STG; k++) sc_vld_q[k] <= 1'b0;
    end else if (en) begin
      if (issue) r_q <= slot_last ? '0 : r_q + PH_W'(1);
      slot_vld_q <= issue;
      for (int s = 0; s < MAX_ORDER; s++) begin
        vld_q[s] <= in_vld[s];
        if (in_vld[s] && (ORD_W'(s) < cfg_i.ord)) acc_q[s] <= sum[s];
      end
      sc_vld_q[0] <= vld_q[MAX_ORDER-1];
      for (int k = 1; k < SC_STG; k++) sc_vld_q[k] <= sc_vld_q[k-1];
    end
  end

  // Payload: slot values, stage outputs, last flags
  always_ff @(posedge clk_i) begin
    if (en) begin
      slot_last_q <= slot_last;
      slot_v_q.i  <= hit ? head_i.i : smp_to_acc(cfg_i.fill_i);
      slot_v_q.q  <= hit ? head_i.q : smp_to_acc(cfg_i.fill_q);
      for (int s = 0; s < MAX_ORDER; s++) begin
        last_q[s] <= in_last[s];
        // stages beyond the order in use pass the value through
        v_q[s]    <= (ORD_W'(s) < cfg_i.ord) ? sum[s] : in_v[s];
      end
      sc_last_q[0] <= last_q[MAX_ORDER-1];
      for (int k = 1; k < SC_STG; k++) sc_last_q[k] <= sc_last_q[k-1];
    end
  end

  cici_scale u_scale_i (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (v_q[MAX_ORDER-1].i),
    .gain_i (cfg_i.gain),
    .y_o    (y_i)
  );

  cici_scale u_scale_q (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (v_q[MAX_ORDER-1].q),
    .gain_i (cfg_i.gain),
    .y_o    (y_q)
  );

  assign out_valid_o      = sc_vld_q[SC_STG-1];
  assign out_data_o.out_i = y_i;
  assign out_data_o.out_q = y_q;
  assign out_data_o.last  = sc_last_q[SC_STG-1];

endmodule

>>> src/cic_interpolator_complex.sv
// Complex CIC interpolator top level: configuration registers, comb front,
// queue and integrator back. Uses cici_pkg, cici_comb, cici_queue, cici_integ.
// Throughput: the comb front runs one comb stage per cycle and takes a new item only
// after handing its result to the queue; the back emits one result per cycle unless
// the output is stalled or the queue is empty.
// Reset clears all filter state and loads register defaults; any write to a known
// register also clears comb and integrator state, not the queue, in the same cycle.
module cic_interpolator_complex import cici_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [ORD_W-1:0]  order_q;
  logic [RAT_W-1:0]  ratio_q;
  logic [DD_W-1:0]   ddly_q;
  logic [PH_W-1:0]   phase_q;
  smp_t              fill_re_q, fill_im_q;
  logic [GAIN_W-1:0] gain_q;

  logic  cfg_hit;
  cfg_t  cfg;
  push_t push;
  logic  push_ready, head_vld, pop;
  cplx_t head;

  // Decode a write to a known register
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORDER, REG_RATIO, REG_DDLY, REG_PHASE,
        REG_FILL_I, REG_FILL_Q, REG_GAIN: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   <= ORDER_RST;
      ratio_q   <= RATIO_RST;
      ddly_q    <= DDLY_RST;
      phase_q   <= '0;
      fill_re_q <= '0;
      fill_im_q <= '0;
      gain_q    <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORDER:  order_q   <= cfg_data_i[ORD_W-1:0];
        REG_RATIO:  ratio_q   <= cfg_data_i[RAT_W-1:0];
        REG_DDLY:   ddly_q    <= cfg_data_i[DD_W-1:0];
        REG_PHASE:  phase_q   <= cfg_data_i[PH_W-1:0];
        REG_FILL_I: fill_re_q <= smp_t'(cfg_data_i[SMP_W-1:0]);
        REG_FILL_Q: fill_im_q <= smp_t'(cfg_data_i[SMP_W-1:0]);
        REG_GAIN:   gain_q    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported ranges
  always_comb begin
    if (order_q == '0) cfg.ord = ORD_W'(1);
    else if (order_q > ORD_W'(MAX_ORDER)) cfg.ord = ORD_W'(MAX_ORDER);
    else cfg.ord = order_q;
    if (ratio_q == '0) cfg.rat = RAT_W'(1);
    else if (ratio_q > RAT_W'(MAX_RATIO)) cfg.rat = RAT_W'(MAX_RATIO);
    else cfg.rat = ratio_q;
    cfg.dd2    = (ddly_q >= DD_W'(MAX_DDLY));
    cfg.phase  = phase_q;
    cfg.fill_i = fill_re_q;
    cfg.fill_q = fill_im_q;
    cfg.gain   = gain_q;
  end

  cici_comb u_comb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clr_i        (cfg_hit),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  cici_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_vld_o   (head_vld),
    .head_o       (head)
  );

  cici_integ u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .clr_i       (cfg_hit),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Front is busy in the cycle after it takes an item, unless a known register write clears it
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front ready right after accepting an item");

  // Clamped settings stay in their legal ranges
  a_cfg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.ord != '0 && cfg.ord <= ORD_W'(MAX_ORDER) &&
    cfg.rat != '0 && cfg.rat <= RAT_W'(MAX_RATIO))
    else $error("effective order or ratio out of range");

  // Registers change only on a write to a known index
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_hit |=> $stable(order_q) && $stable(ratio_q) && $stable(ddly_q) &&
                 $stable(phase_q) && $stable(fill_re_q) && $stable(fill_im_q) &&
                 $stable(gain_q))
    else $error("configuration changed without a write");

endmodule

>>> verif/cic_interpolator_complex_test.sv
// Self-checking testbench for the complex CIC interpolator: a directed table, then random
// register settings and samples, each output compared against a bit-exact filter model.
// Depends on cici_pkg and cic_interpolator_complex from src.
module cic_interpolator_complex_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cici_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_MAX     = 10;
  localparam int PHASE_ITEMS    = 26;
  localparam int PRESSURE_ITEMS = 80;

  // index that decodes to no register
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  // one row of the directed table: a register write or a sample
  typedef struct {
    bit               is_write;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] value;
    in_t              smp;
    bit               known;
    smp_t             want_i;
    smp_t             want_q;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_t             out_data_o;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  // fixed result attached to the sample on offer, if the table gives one
  bit   want_known;
  smp_t want_i;
  smp_t want_q;

  // register mirror
  logic [ORD_W-1:0]  cur_order;
  logic [RAT_W-1:0]  cur_ratio;
  logic [DD_W-1:0]   cur_ddly;
  logic [PH_W-1:0]   cur_phase;
  smp_t              cur_fill_i;
  smp_t              cur_fill_q;
  logic [GAIN_W-1:0] cur_gain;

  // filter state mirror
  acc_t comb_hist_i [MAX_ORDER][MAX_DDLY];
  acc_t comb_hist_q [MAX_ORDER][MAX_DDLY];
  int   comb_slot   [MAX_ORDER];
  acc_t integ_i     [MAX_ORDER];
  acc_t integ_q     [MAX_ORDER];

  out_t      outs_due[$];
  out_t      due;
  plan_row_t plan[$];

  int  faults;
  int  samples_in;
  int  results_seen;
  int  reg_writes;
  bit  tx_quiet;
  bit  hold_go;

  cic_interpolator_complex DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int clamp_to(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void clear_filter();
    for (int s = 0; s < MAX_ORDER; s++) begin
      for (int d = 0; d < MAX_DDLY; d++) begin
        comb_hist_i[s][d] = '0;
        comb_hist_q[s][d] = '0;
      end
      comb_slot[s] = 0;
      integ_i[s]   = '0;
      integ_q[s]   = '0;
    end
  endfunction

  // update the mirror; a known register also flushes the filter
  function automatic void apply_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_ORDER:  cur_order  = d[ORD_W-1:0];
      REG_RATIO:  cur_ratio  = d[RAT_W-1:0];
      REG_DDLY:   cur_ddly   = d[DD_W-1:0];
      REG_PHASE:  cur_phase  = d[PH_W-1:0];
      REG_FILL_I: cur_fill_i = d[SMP_W-1:0];
      REG_FILL_Q: cur_fill_q = d[SMP_W-1:0];
      REG_GAIN:   cur_gain   = d[GAIN_W-1:0];
      default:    return;
    endcase
    clear_filter();
  endfunction

  // floor(acc * gain / 2^32), saturated to the sample range
  function automatic smp_t scale_sample(acc_t a);
    logic signed [95:0] wide_a;
    logic signed [95:0] wide_g;
    logic signed [95:0] prod;
    wide_a = 96'(a);
    wide_g = 96'(cur_gain);
    prod   = (wide_a * wide_g) >>> 32;
    if (prod > 96'sd32767) return 16'sh7FFF;
    if (prod < -96'sd32768) return 16'sh8000;
    return prod[SMP_W-1:0];
  endfunction

  // run one sample through comb and integrator chains, queue its outputs
  function automatic void predict_outputs(in_t smp, bit known, smp_t wi, smp_t wq);
    int   ord;
    int   rat;
    int   dd;
    int   slot;
    acc_t ci;
    acc_t cq;
    acc_t di;
    acc_t dq;
    acc_t vi;
    acc_t vq;
    out_t o;
    ord = clamp_to(int'(cur_order), MAX_ORDER);
    rat = clamp_to(int'(cur_ratio), MAX_RATIO);
    dd  = clamp_to(int'(cur_ddly), MAX_DDLY);
    ci  = acc_t'(smp.in_i);
    cq  = acc_t'(smp.in_q);
    // comb chain at the low rate
    for (int s = 0; s < ord; s++) begin
      slot = comb_slot[s];
      if (slot >= dd) slot = 0;
      di = comb_hist_i[s][slot];
      dq = comb_hist_q[s][slot];
      comb_hist_i[s][slot] = ci;
      comb_hist_q[s][slot] = cq;
      comb_slot[s] = (slot + 1 >= dd) ? 0 : slot + 1;
      ci = ci - di;
      cq = cq - dq;
    end
    // one integrator pass per high-rate slot
    for (int r = 0; r < rat; r++) begin
      if (r == int'(cur_phase)) begin
        vi = ci;
        vq = cq;
      end else begin
        vi = acc_t'(cur_fill_i);
        vq = acc_t'(cur_fill_q);
      end
      for (int s = 0; s < ord; s++) begin
        integ_i[s] = integ_i[s] + vi;
        integ_q[s] = integ_q[s] + vq;
        vi = integ_i[s];
        vq = integ_q[s];
      end
      o.out_i = known ? wi : scale_sample(vi);
      o.out_q = known ? wq : scale_sample(vq);
      o.last  = (r == rat - 1);
      outs_due.push_back(o);
    end
  endfunction

  function automatic plan_row_t reg_row(logic [IDX_W-1:0] idx, longint value);
    plan_row_t r;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.value    = CFG_W'(value);
    r.smp      = '0;
    r.known    = 1'b0;
    r.want_i   = '0;
    r.want_q   = '0;
    return r;
  endfunction

  function automatic plan_row_t sample_row(int i, int q, bit known = 1'b0, int wi = 0,
                                           int wq = 0);
    plan_row_t r;
    r.is_write  = 1'b0;
    r.idx       = '0;
    r.value     = '0;
    r.smp.in_i  = smp_t'(i);
    r.smp.in_q  = smp_t'(q);
    r.known     = known;
    r.want_i    = smp_t'(wi);
    r.want_q    = smp_t'(wq);
    return r;
  endfunction

  // put random junk above a register's width now and then
  function automatic logic [CFG_W-1:0] with_junk(longint v, int w);
    logic [CFG_W-1:0] junk;
    logic [CFG_W-1:0] mask;
    junk = CFG_W'({$urandom, $urandom});
    mask = (CFG_W'(1) << w) - CFG_W'(1);
    if (w >= CFG_W || $urandom_range(3) != 0) return CFG_W'(v);
    return (junk & ~mask) | (CFG_W'(v) & mask);
  endfunction

  function automatic in_t random_sample();
    in_t s;
    case ($urandom_range(5))
      0: begin
        s.in_i = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        s.in_q = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      1: begin
        s.in_i = smp_t'(int'($urandom_range(127)) - 64);
        s.in_q = smp_t'(int'($urandom_range(127)) - 64);
      end
      default: s = in_t'($urandom);
    endcase
    return s;
  endfunction

  // offer one item and hold it until accepted; returns on a falling edge
  task automatic send_sample(in_t smp, bit known, smp_t wi, smp_t wq);
    int gap;
    gap = tx_quiet ? 0 : int'($urandom_range(10));
    cfg_we_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= smp;
    want_known <= known;
    want_i     <= wi;
    want_q     <= wq;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!(in_valid_i && in_ready_o)) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid and wait for every queued output
  task automatic drain();
    in_valid_i <= 1'b0;
    while (outs_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic random_setting();
    int     ord;
    int     rat;
    int     dd;
    int     ph;
    int     sel;
    longint gain;
    real    den;
    sel = $urandom_range(9);
    ord = (sel == 0) ? 0 : (sel == 1) ? 7 : int'($urandom_range(6, 1));
    sel = $urandom_range(9);
    case (sel)
      0:       rat = 0;
      1:       rat = 127;
      2:       rat = MAX_RATIO;
      3:       rat = $urandom_range(63, 9);
      default: rat = $urandom_range(8, 1);
    endcase
    dd = $urandom_range(3);
    if ($urandom_range(4) == 0) ph = $urandom_range(63);
    else ph = $urandom_range(clamp_to(rat, MAX_RATIO) - 1);
    // nominal gain R / (R*M)^N as a fraction of 2^32
    den = 1.0;
    repeat (clamp_to(ord, MAX_ORDER) - 1) den = den * clamp_to(rat, MAX_RATIO);
    repeat (clamp_to(ord, MAX_ORDER)) den = den * clamp_to(dd, MAX_DDLY);
    case ($urandom_range(7))
      0:       gain = 0;
      1:       gain = 64'h1_0000_0000;
      2:       gain = (longint'($urandom_range(1)) << 32) | longint'($urandom);
      default: gain = longint'(4294967296.0 / den);
    endcase
    write_reg(REG_ORDER, with_junk(ord, ORD_W));
    write_reg(REG_RATIO, with_junk(rat, RAT_W));
    write_reg(REG_DDLY, with_junk(dd, DD_W));
    write_reg(REG_PHASE, with_junk(ph, PH_W));
    sel = $urandom_range(2);
    write_reg(REG_FILL_I, with_junk((sel == 0) ? 0 : $urandom_range(65535), SMP_W));
    write_reg(REG_FILL_Q, with_junk((sel == 0) ? 0 : $urandom_range(65535), SMP_W));
    write_reg(REG_GAIN, with_junk(gain, GAIN_W));
  endtask

  // predict on accepted inputs, compare accepted outputs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (out_valid_o && out_ready_i) begin
        if (outs_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX)
            $display("%0t: output with nothing due: i=%0d q=%0d last=%0b", $time,
                     out_data_o.out_i, out_data_o.out_q, out_data_o.last);
        end else begin
          due = outs_due.pop_front();
          if (out_data_o.out_i !== due.out_i || out_data_o.out_q !== due.out_q ||
              out_data_o.last !== due.last) begin
            faults++;
            if (faults <= REPORT_MAX)
              $display("%0t: output %0d: want i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                       $time, results_seen, due.out_i, due.out_q, due.last,
                       out_data_o.out_i, out_data_o.out_q, out_data_o.last);
          end
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        predict_outputs(in_data_i, want_known, want_i, want_q);
        samples_in++;
      end
    end
  end

  // output side: random stalls per item, one long hold-off on request
  initial begin : sink
    int stall;
    int taken;
    bit hold_done;
    bit rx_quiet;
    taken       = 0;
    hold_done   = 1'b0;
    rx_quiet    = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (taken % 50 == 0) rx_quiet = ($urandom_range(3) == 0);
      stall = rx_quiet ? 0 : int'($urandom_range(10));
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
      taken++;
    end
  end

  // end the run when nothing has been accepted for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    // mirror starts at register defaults with an empty filter
    cur_order  = ORDER_RST;
    cur_ratio  = RATIO_RST;
    cur_ddly   = DDLY_RST;
    cur_phase  = '0;
    cur_fill_i = '0;
    cur_fill_q = '0;
    cur_gain   = GAIN_RST;
    clear_filter();
    faults       = 0;
    samples_in   = 0;
    results_seen = 0;
    reg_writes   = 0;
    tx_quiet     = 1'b0;
    hold_go      = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    want_known   = 1'b0;
    want_i       = '0;
    want_q       = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;

    // zero in after reset gives zero out
    plan.push_back(sample_row(0, 0, 1'b1, 0, 0));
    plan.push_back(sample_row(32767, -32768));
    plan.push_back(sample_row(-32768, 32767));
    plan.push_back(sample_row(-1, 1));
    // unity gain, full order and ratio: a full-scale step saturates every slot
    plan.push_back(reg_row(REG_GAIN, 64'h1_0000_0000));
    plan.push_back(reg_row(REG_ORDER, 6));
    plan.push_back(reg_row(REG_RATIO, 64));
    plan.push_back(reg_row(REG_PHASE, 0));
    plan.push_back(sample_row(32767, 32767, 1'b1, 32767, 32767));
    plan.push_back(reg_row(REG_FILL_I, 0));
    plan.push_back(sample_row(-32768, -32768, 1'b1, -32768, -32768));
    plan.push_back(sample_row(12345, -2222));
    // zero gain silences everything
    plan.push_back(reg_row(REG_GAIN, 0));
    plan.push_back(sample_row(32767, -32768, 1'b1, 0, 0));
    // zero order, ratio and delay act as one
    plan.push_back(reg_row(REG_ORDER, 0));
    plan.push_back(reg_row(REG_RATIO, 0));
    plan.push_back(reg_row(REG_DDLY, 0));
    plan.push_back(reg_row(REG_GAIN, 64'h8000_0000));
    plan.push_back(sample_row(1000, -1000));
    plan.push_back(sample_row(-3, 7));
    plan.push_back(sample_row(32767, 0));
    // oversized order, ratio and delay clamp to their maximum
    plan.push_back(reg_row(REG_ORDER, 7));
    plan.push_back(reg_row(REG_RATIO, 127));
    plan.push_back(reg_row(REG_DDLY, 3));
    plan.push_back(reg_row(REG_PHASE, 63));
    plan.push_back(reg_row(REG_GAIN, 64'h10_0000));
    plan.push_back(sample_row(-32768, 32767));
    plan.push_back(sample_row(5, -5));
    // phase past ratio: only fill reaches the integrators
    plan.push_back(reg_row(REG_RATIO, 4));
    plan.push_back(reg_row(REG_PHASE, 5));
    plan.push_back(reg_row(REG_FILL_I, 64'h8000));
    plan.push_back(reg_row(REG_FILL_Q, 64'h7FFF));
    plan.push_back(reg_row(REG_ORDER, 2));
    plan.push_back(reg_row(REG_GAIN, 64'h100_0000));
    plan.push_back(sample_row(100, 200));
    plan.push_back(sample_row(-100, 300));
    // a write to no register keeps the filter state
    plan.push_back(reg_row(REG_NONE, 64'h1_FFFF_FFFF));
    plan.push_back(sample_row(7, 8));
    // single stage, delay two, unity gain
    plan.push_back(reg_row(REG_ORDER, 1));
    plan.push_back(reg_row(REG_RATIO, 1));
    plan.push_back(reg_row(REG_DDLY, 2));
    plan.push_back(reg_row(REG_PHASE, 0));
    plan.push_back(reg_row(REG_FILL_I, 0));
    plan.push_back(reg_row(REG_FILL_Q, 0));
    plan.push_back(reg_row(REG_GAIN, 64'h1_0000_0000));
    plan.push_back(sample_row(10, -10));
    plan.push_back(sample_row(20, -20));
    plan.push_back(sample_row(30, -30));
    plan.push_back(sample_row(-32768, 32767));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // walk the directed table; registers change only with the pipe empty
    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        drain();
        write_reg(plan[k].idx, plan[k].value);
      end else begin
        send_sample(plan[k].smp, plan[k].known, plan[k].want_i, plan[k].want_q);
      end
    end

    // random settings; the second pass uses a fixed setting and backs up the output with a long hold-off
    for (int p = 0; p < 6; p++) begin
      drain();
      if (p == 1) begin
        write_reg(REG_ORDER, 1);
        write_reg(REG_RATIO, 2);
        write_reg(REG_DDLY, 1);
        write_reg(REG_PHASE, 0);
        write_reg(REG_FILL_I, 0);
        write_reg(REG_FILL_Q, 0);
        write_reg(REG_GAIN, 64'h1000_0000);
        tx_quiet = 1'b1;
        hold_go  = 1'b1;
        repeat (PRESSURE_ITEMS) send_sample(random_sample(), 1'b0, '0, '0);
      end else begin
        random_setting();
        tx_quiet = ($urandom_range(3) == 0);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          // poke the unused index mid-stream now and then
          if (n == PHASE_ITEMS / 2 && $urandom_range(3) == 0) begin
            drain();
            write_reg(REG_NONE, CFG_W'({$urandom, $urandom}));
          end
          send_sample(random_sample(), 1'b0, '0, '0);
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Ran %0d samples and %0d outputs through %0d register writes,", samples_in,
             results_seen, reg_writes);
    $display("with clamped fields, phase past ratio and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
